[sv/u2c_pkg.sv]
package u2c_pkg;

	// Glyph used for anything without a CP437 mapping
	localparam logic [7:0]  GLYPH_REPL = 8'hFE;
	// Highest code point that passes through unchanged
	localparam logic [20:0] ASCII_MAX  = 21'h00007F;

	// Input transaction
	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       end_of_string;
	} in_item_t;

	// Result transaction
	typedef struct packed {
		logic [7:0] glyph_code;
		logic       glyph_valid;
		logic       string_done;
		logic [9:0] glyph_count;
	} out_item_t;

	// Unicode code point to CP437 glyph
	function automatic logic [7:0] map_code(input logic [20:0] code);
		logic [7:0] g;
		g = GLYPH_REPL;
		if (code <= ASCII_MAX) begin
			g = code[7:0];
		end else begin
			case (code)
				21'h002302: g = 8'h7F;
				// control-range pictographs
				21'h00263A: g = 8'h01;  21'h00263B: g = 8'h02;
				21'h002665: g = 8'h03;  21'h002666: g = 8'h04;
				21'h002663: g = 8'h05;  21'h002660: g = 8'h06;
				21'h002022: g = 8'h07;  21'h0025D8: g = 8'h08;
				21'h0025CB: g = 8'h09;  21'h002642: g = 8'h0B;
				21'h002640: g = 8'h0C;  21'h00266B: g = 8'h0E;
				21'h00263C: g = 8'h0F;  21'h0025BA: g = 8'h10;
				21'h0025C4: g = 8'h11;  21'h002195: g = 8'h12;
				21'h00203C: g = 8'h13;  21'h0000B6: g = 8'h14;
				21'h0000A7: g = 8'h15;  21'h0025AC: g = 8'h16;
				21'h0021A8: g = 8'h17;  21'h002191: g = 8'h18;
				21'h002193: g = 8'h19;  21'h002192: g = 8'h1A;
				21'h002190: g = 8'h1B;  21'h00221F: g = 8'h1C;
				21'h002194: g = 8'h1D;  21'h0025B2: g = 8'h1E;
				21'h0025BC: g = 8'h1F;
				// upper half
				21'h0000C7: g = 8'h80;  21'h0000FC: g = 8'h81;
				21'h0000E9: g = 8'h82;  21'h0000E2: g = 8'h83;
				21'h0000E4: g = 8'h84;  21'h0000E0: g = 8'h85;
				21'h0000E5: g = 8'h86;  21'h0000E7: g = 8'h87;
				21'h0000EA: g = 8'h88;  21'h0000EB: g = 8'h89;
				21'h0000E8: g = 8'h8A;  21'h0000EF: g = 8'h8B;
				21'h0000EE: g = 8'h8C;  21'h0000EC: g = 8'h8D;
				21'h0000C4: g = 8'h8E;  21'h0000C5: g = 8'h8F;
				21'h0000C9: g = 8'h90;  21'h0000E6: g = 8'h91;
				21'h0000C6: g = 8'h92;  21'h0000F4: g = 8'h93;
				21'h0000F6: g = 8'h94;  21'h0000F2: g = 8'h95;
				21'h0000FB: g = 8'h96;  21'h0000F9: g = 8'h97;
				21'h0000FF: g = 8'h98;  21'h0000D6: g = 8'h99;
				21'h0000DC: g = 8'h9A;  21'h0000A2: g = 8'h9B;
				21'h0000A3: g = 8'h9C;  21'h0000A5: g = 8'h9D;
				21'h0020A7: g = 8'h9E;  21'h000192: g = 8'h9F;
				21'h0000E1: g = 8'hA0;  21'h0000ED: g = 8'hA1;
				21'h0000F3: g = 8'hA2;  21'h0000FA: g = 8'hA3;
				21'h0000F1: g = 8'hA4;  21'h0000D1: g = 8'hA5;
				21'h0000AA: g = 8'hA6;  21'h0000BA: g = 8'hA7;
				21'h0000BF: g = 8'hA8;  21'h002310: g = 8'hA9;
				21'h0000AC: g = 8'hAA;  21'h0000BD: g = 8'hAB;
				21'h0000BC: g = 8'hAC;  21'h0000A1: g = 8'hAD;
				21'h0000AB: g = 8'hAE;  21'h0000BB: g = 8'hAF;
				21'h002591: g = 8'hB0;  21'h002592: g = 8'hB1;
				21'h002593: g = 8'hB2;  21'h002502: g = 8'hB3;
				21'h002524: g = 8'hB4;  21'h002561: g = 8'hB5;
				21'h002562: g = 8'hB6;  21'h002556: g = 8'hB7;
				21'h002555: g = 8'hB8;  21'h002563: g = 8'hB9;
				21'h002551: g = 8'hBA;  21'h002557: g = 8'hBB;
				21'h00255D: g = 8'hBC;  21'h00255C: g = 8'hBD;
				21'h00255B: g = 8'hBE;  21'h002510: g = 8'hBF;
				21'h002514: g = 8'hC0;  21'h002534: g = 8'hC1;
				21'h00252C: g = 8'hC2;  21'h00251C: g = 8'hC3;
				21'h002500: g = 8'hC4;  21'h00253C: g = 8'hC5;
				21'h00255E: g = 8'hC6;  21'h00255F: g = 8'hC7;
				21'h00255A: g = 8'hC8;  21'h002554: g = 8'hC9;
				21'h002569: g = 8'hCA;  21'h002566: g = 8'hCB;
				21'h002560: g = 8'hCC;  21'h002550: g = 8'hCD;
				21'h00256C: g = 8'hCE;  21'h002567: g = 8'hCF;
				21'h002568: g = 8'hD0;  21'h002564: g = 8'hD1;
				21'h002565: g = 8'hD2;  21'h002559: g = 8'hD3;
				21'h002558: g = 8'hD4;  21'h002552: g = 8'hD5;
				21'h002553: g = 8'hD6;  21'h00256B: g = 8'hD7;
				21'h00256A: g = 8'hD8;  21'h002518: g = 8'hD9;
				21'h00250C: g = 8'hDA;  21'h002588: g = 8'hDB;
				21'h002584: g = 8'hDC;  21'h00258C: g = 8'hDD;
				21'h002590: g = 8'hDE;  21'h002580: g = 8'hDF;
				21'h0003B1: g = 8'hE0;  21'h0000DF: g = 8'hE1;
				21'h000393: g = 8'hE2;  21'h0003C0: g = 8'hE3;
				21'h0003A3: g = 8'hE4;  21'h0003C3: g = 8'hE5;
				21'h0000B5: g = 8'hE6;  21'h0003C4: g = 8'hE7;
				21'h0003A6: g = 8'hE8;  21'h000398: g = 8'hE9;
				21'h0003A9: g = 8'hEA;  21'h0003B4: g = 8'hEB;
				21'h00221E: g = 8'hEC;  21'h0003C6: g = 8'hED;
				21'h0003B5: g = 8'hEE;  21'h002229: g = 8'hEF;
				21'h002261: g = 8'hF0;  21'h0000B1: g = 8'hF1;
				21'h002265: g = 8'hF2;  21'h002264: g = 8'hF3;
				21'h002320: g = 8'hF4;  21'h002321: g = 8'hF5;
				21'h0000F7: g = 8'hF6;  21'h002248: g = 8'hF7;
				21'h0000B0: g = 8'hF8;  21'h002219: g = 8'hF9;
				21'h0000B7: g = 8'hFA;  21'h00221A: g = 8'hFB;
				21'h00207F: g = 8'hFC;  21'h0000B2: g = 8'hFD;
				21'h0025A0: g = 8'hFE;  21'h0000A0: g = 8'hFF;
				default:    g = GLYPH_REPL;
			endcase
		end
		return g;
	endfunction

endpackage

[sv/utf8_to_cp437_converter.sv]
// UTF-8 to CP437 glyph converter.
// Input channel (in_valid/in_stall/in_data) takes one string byte per
// transaction, with end_of_string set on the final byte. Output channel
// (out_valid/out_stall/out_data) delivers a transaction for every emitted
// glyph and one for the final byte, which carries the glyph count.
// Bytes that only open or extend a multi-byte sequence give no output.
// Timing: a byte is registered at the input stage, then decoded and looked up
// while it waits there; its result lands in the output register once the
// output is free, and out_valid rises if the byte gives a result.
// One byte per cycle is sustained while the output is not stalled; the input
// register and the output register each hold one transaction.
// A stalled output holds its transaction; the input stage then fills and
// in_stall rises. The decode state advances only when a byte leaves the
// input stage.
// cfg_wr_en/cfg_wr_data set max_chars (reset 1023) and should be written
// while the block is idle.
// Reset (arst_n low) empties both stages and clears the decoder state.
module utf8_to_cp437_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  u2c_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output u2c_pkg::out_item_t  out_data,
	input  logic                cfg_wr_en,
	input  logic [9:0]          cfg_wr_data
);

	logic                s1_valid_q;
	u2c_pkg::in_item_t   s1_item_s1;
	logic [9:0]          max_chars_q;
	logic                out_valid_q;
	u2c_pkg::out_item_t  out_data_q;
	logic                out_free;
	logic                step;
	logic                has_result;
	u2c_pkg::out_item_t  result;

	assign out_free = !out_valid_q || !out_stall;
	assign step     = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !out_free;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_chars_q <= 10'd1023;
		else if (cfg_wr_en)
			max_chars_q <= cfg_wr_data;
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (!in_stall)
			s1_valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			s1_item_s1 <= in_data;
	end

	u2c_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (s1_item_s1),
		.max_chars  (max_chars_q),
		.has_result (has_result),
		.result     (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= has_result;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && has_result)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Input stage only holds back when it has a transaction waiting
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("in_stall without a pending byte");

	// A waiting byte is not lost while the output is blocked
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> s1_valid_q && $stable(s1_item_s1))
		else $error("input stage lost its byte while stalled");

	// Every result carries a glyph or ends a string
	a_result_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.glyph_valid |-> out_data.string_done)
		else $error("empty result without end of string");

	// Fields not in use are zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.glyph_valid || out_data.glyph_code == 8'd0) &&
		(out_data.string_done || out_data.glyph_count == 10'd0))
		else $error("unused result field not zero");

	// Output holds while stalled
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

[sv/u2c_decode.sv]
module u2c_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  u2c_pkg::in_item_t   item,
	input  logic [9:0]          max_chars,
	output logic                has_result,
	output u2c_pkg::out_item_t  result
);

	logic [20:0] acc_q;
	logic [1:0]  cont_q;
	logic [9:0]  cnt_q;

	logic [20:0] acc_n;
	logic [1:0]  cont_n;
	logic [9:0]  cnt_n;
	logic [20:0] code;
	logic        complete;
	logic        bad;
	logic        emit;
	logic [7:0]  b;
	logic        is_cont;

	assign b       = item.utf8_byte;
	assign is_cont = (b[7:6] == 2'b10);

	// UTF-8 sequence assembly
	always_comb begin
		acc_n    = '0;
		cont_n   = '0;
		code     = '0;
		complete = 1'b0;
		bad      = 1'b0;
		if (cont_q != 2'd0 && is_cont) begin
			acc_n  = {acc_q[14:0], b[5:0]};
			cont_n = cont_q - 2'd1;
			code   = acc_n;
			complete = (cont_n == 2'd0);
		end else if (!b[7]) begin
			complete = 1'b1;
			code     = {13'd0, b};
		end else if (is_cont) begin
			// stray continuation byte
			complete = 1'b1;
			bad      = 1'b1;
		end else if (b[7:5] == 3'b110) begin
			acc_n  = {16'd0, b[4:0]};
			cont_n = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			acc_n  = {17'd0, b[3:0]};
			cont_n = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			acc_n  = {18'd0, b[2:0]};
			cont_n = 2'd3;
		end else begin
			// invalid lead byte
			complete = 1'b1;
			bad      = 1'b1;
		end
	end

	// Limit check, glyph lookup and result
	assign emit  = complete && (cnt_q < max_chars);
	assign cnt_n = emit ? cnt_q + 10'd1 : cnt_q;

	always_comb begin
		result.glyph_code  = '0;
		if (emit)
			result.glyph_code = bad ? u2c_pkg::GLYPH_REPL : u2c_pkg::map_code(code);
		result.glyph_valid = emit;
		result.string_done = item.end_of_string;
		result.glyph_count = item.end_of_string ? cnt_n : 10'd0;
	end

	assign has_result = emit || item.end_of_string;

	// Decoder state; cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cont_q <= '0;
			cnt_q  <= '0;
		end else if (step) begin
			if (item.end_of_string) begin
				acc_q  <= '0;
				cont_q <= '0;
				cnt_q  <= '0;
			end else begin
				acc_q  <= acc_n;
				cont_q <= cont_n;
				cnt_q  <= cnt_n;
			end
		end
	end

endmodule
